// ----- src/tvi_pkg.sv -----
package tvi_pkg;

  localparam int BUDGET_ROWS  = 8;
  localparam int OUTPUT_COUNT = 8;
  localparam int ROW_W        = $clog2(BUDGET_ROWS);
  localparam int COL_W        = $clog2(OUTPUT_COUNT);
  localparam int TBL_AW       = ROW_W + COL_W;
  localparam int DATA_W       = 16;
  localparam int FRAC_W       = 4;
  localparam int FRAC_MAX     = 14;
  localparam int FRAC_RESET   = 10;
  // dividend magnitude is up to 2^15 scaled by 2^FRAC_MAX
  localparam int DVD_W        = DATA_W + FRAC_MAX;
  localparam int CNT_W        = $clog2(DVD_W);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(BUDGET_ROWS - 1);
  localparam logic [COL_W-1:0] OUT_LAST = COL_W'(OUTPUT_COUNT - 1);

  typedef enum logic [1:0] {
    OP_LOAD_BUDGET = 2'd0,
    OP_LOAD_ENERGY = 2'd1,
    OP_LOAD_THRESH = 2'd2,
    OP_INTERP      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_ONE   = 2'd1,
    MODE_BLEND = 2'd2
  } mode_e;

  typedef struct packed {
    logic             srch_en;
    logic [ROW_W-1:0] k;
    logic             ld_elo;
    logic             div_start;
    logic             rd_lo;
    logic             mul_lo;
    logic             acc_lo;
    logic             mul_hi;
    logic             acc_hi;
    logic             emit;
    logic [COL_W-1:0] idx;
  } tvi_cmd_t;

  typedef struct packed {
    logic blend;
    logic need_div;
    logic div_done;
    logic out_free;
  } tvi_stat_t;

endpackage

// ----- src/threshold_vector_interpolator.sv -----
// loads produce no transfer
// interpolate: search the budget rows, load the low-row energy, run the divider when rows bracket,
// then per blended output read, multiply and accumulate low and high rows (shared multiplier,
// one table read port) before emitting, or emit directly otherwise; one item in work at a time
// reset clears control and sets frac_bits to 10; tables are undefined until loaded
module threshold_vector_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row, column, load_value, target, zero pad
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_index, threshold, zero pad
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tvi_pkg::*;

  logic              in_xfer;
  logic              start;
  logic              idle;
  logic [FRAC_W-1:0] frac_q;
  logic [FRAC_W-1:0] frac_eff;
  tvi_cmd_t          cmd;
  tvi_stat_t         stat;
  logic [2:0]        oidx;
  logic [15:0]       oval;

  assign pready = 1'b1;
  assign prdata = {{(32-FRAC_W){1'b0}}, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRAC_W'(FRAC_RESET);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      frac_q <= pwdata[FRAC_W-1:0];
    end
  end

  assign frac_eff = (frac_q > FRAC_W'(FRAC_MAX)) ? FRAC_W'(FRAC_MAX) : frac_q;

  assign s_axis_tready = idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign start         = in_xfer && (s_axis_tuser == OP_INTERP);

  tvi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .idle_o  (idle)
  );

  tvi_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_xfer),
    .opcode_i     (s_axis_tuser),
    .row_i        (s_axis_tdata[2:0]),
    .column_i     (s_axis_tdata[5:3]),
    .load_value_i (s_axis_tdata[21:6]),
    .start_i      (start),
    .target_i     (s_axis_tdata[37:22]),
    .frac_i       (frac_eff),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_index_o  (oidx),
    .threshold_o  (oval),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, oval, oidx};

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("input taken while an interpolation is in progress");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2:0] == 3'(OUT_LAST)))
    else $error("last flag on wrong output index");

  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[18:3] == 16'd0))
    else $error("final threshold not zero");

endmodule

// ----- src/tvi_div.sv -----
module tvi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tvi_pkg::DVD_W-1:0] dividend_i,
  input  logic [15:0]               divisor_i,
  input  logic                      neg_i,
  output logic                      done_o,
  output logic [15:0]               quot_o
);
  import tvi_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [15:0]      dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [16:0]      rem_sh;
  logic [16:0]      diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      neg_d  = neg_i;
    end else if (busy_q) begin
      // one restoring step per cycle
      rem_d = ge ? diff[15:0] : rem_sh[15:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 16'(-quo_q[15:0]) : quo_q[15:0];

endmodule

// ----- src/tvi_datapath.sv -----
module tvi_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [1:0]                opcode_i,
  input  logic [2:0]                row_i,
  input  logic [2:0]                column_i,
  input  logic [15:0]               load_value_i,
  input  logic                      start_i,
  input  logic [15:0]               target_i,
  input  logic [3:0]                frac_i,
  input  tvi_pkg::tvi_cmd_t         cmd_i,
  output tvi_pkg::tvi_stat_t        stat_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [2:0]                out_index_o,
  output logic [15:0]               threshold_o,
  output logic                      last_o
);
  import tvi_pkg::*;

  logic signed [15:0] budget_q [BUDGET_ROWS];
  logic signed [15:0] energy_q [BUDGET_ROWS];
  logic signed [15:0] thr_mem  [BUDGET_ROWS*OUTPUT_COUNT];
  logic signed [15:0] thr_rd_q;
  logic [TBL_AW-1:0]  rd_addr;

  logic signed [15:0] target_q;
  logic signed [15:0] prev_q;
  logic signed [15:0] btop_q;
  logic signed [15:0] bk;
  logic               found_q, found_nx;
  logic [ROW_W-1:0]   lo_q, lo_nx, hi_q, hi_nx;
  mode_e              mode_q, mode_nx;
  logic               need_div_q, need_div_nx;

  logic signed [15:0] elo_q;
  logic signed [15:0] num, den;
  logic [15:0]        num_mag, den_mag;
  logic               den_zero_q;
  logic               div_done;
  logic [15:0]        div_quot;

  logic [15:0]        one;
  logic signed [15:0] weight_q;
  logic signed [15:0] wclamp;

  logic signed [15:0] mul_b;
  logic signed [31:0] prod_q;
  logic signed [31:0] prod_sh;
  logic signed [15:0] term;
  logic signed [15:0] acc_q;
  logic signed [15:0] emit_val;

  logic               ovalid_q;
  logic [2:0]         oidx_q;
  logic [15:0]        oval_q;
  logic               olast_q;
  logic               out_free;

  assign one = 16'd1 << frac_i;

  // table writes and the registered table read
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      case (opcode_i)
        OP_LOAD_BUDGET: budget_q[row_i] <= load_value_i;
        OP_LOAD_ENERGY: energy_q[row_i] <= load_value_i;
        OP_LOAD_THRESH: thr_mem[{row_i, column_i}] <= load_value_i;
        default: ;
      endcase
    end
    if (cmd_i.rd_lo || cmd_i.acc_lo) begin
      thr_rd_q <= thr_mem[rd_addr];
    end
  end

  assign rd_addr = cmd_i.acc_lo ? {hi_q, cmd_i.idx} : {lo_q, cmd_i.idx};

  // bracket search, top row down, one budget entry per cycle
  assign bk = budget_q[cmd_i.k];

  always_comb begin
    found_nx    = found_q;
    lo_nx       = lo_q;
    hi_nx       = hi_q;
    mode_nx     = mode_q;
    need_div_nx = need_div_q;
    if (cmd_i.k == ROW_LAST) begin
      found_nx = (target_q == bk);
      lo_nx    = cmd_i.k;
      hi_nx    = cmd_i.k;
    end else if (!found_q) begin
      if (target_q > bk && target_q < prev_q) begin
        found_nx = 1'b1;
        lo_nx    = cmd_i.k;
        hi_nx    = cmd_i.k + 1'b1;
      end else if (target_q == bk) begin
        found_nx = 1'b1;
        lo_nx    = cmd_i.k;
        hi_nx    = cmd_i.k;
      end
    end
    if (cmd_i.k == '0) begin
      need_div_nx = 1'b0;
      if (target_q == bk) begin
        mode_nx = MODE_BLEND;
        lo_nx   = '0;
        hi_nx   = '0;
      end else if (target_q < bk) begin
        mode_nx = MODE_ZERO;
      end else if (target_q > btop_q) begin
        mode_nx = MODE_ONE;
      end else if (!found_nx) begin
        mode_nx = MODE_ZERO;
      end else begin
        mode_nx     = MODE_BLEND;
        need_div_nx = (lo_nx != hi_nx);
      end
    end
  end

  // weight
  assign num     = target_q - elo_q;
  assign den     = energy_q[hi_q] - elo_q;
  assign num_mag = num[15] ? 16'(-num) : num;
  assign den_mag = den[15] ? 16'(-den) : den;

  tvi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({{(DVD_W-16){1'b0}}, num_mag} << frac_i),
    .divisor_i  (den_mag),
    .neg_i      (num[15] ^ den[15]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    if ($signed(div_quot) < 0) begin
      wclamp = '0;
    end else if ($signed(div_quot) > $signed(one)) begin
      wclamp = one;
    end else begin
      wclamp = div_quot;
    end
  end

  // blend: one shared multiplier
  assign mul_b   = cmd_i.mul_hi ? weight_q : 16'(one - weight_q);
  assign prod_sh = prod_q >>> frac_i;
  assign term    = prod_sh[15:0];

  always_comb begin
    case (mode_q)
      MODE_ONE:   emit_val = one;
      MODE_BLEND: emit_val = acc_q;
      default:    emit_val = '0;
    endcase
    if (cmd_i.idx == OUT_LAST) begin
      emit_val = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      target_q <= target_i;
    end
    if (cmd_i.srch_en) begin
      found_q    <= found_nx;
      lo_q       <= lo_nx;
      hi_q       <= hi_nx;
      mode_q     <= mode_nx;
      need_div_q <= need_div_nx;
      prev_q     <= bk;
      if (cmd_i.k == ROW_LAST) begin
        btop_q <= bk;
      end
      if (cmd_i.k == '0) begin
        weight_q <= one;
      end
    end
    if (cmd_i.ld_elo) begin
      elo_q <= energy_q[lo_q];
    end
    if (cmd_i.div_start) begin
      den_zero_q <= (den == '0);
    end
    if (div_done && !den_zero_q) begin
      weight_q <= wclamp;
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      prod_q <= thr_rd_q * mul_b;
    end
    if (cmd_i.acc_lo) begin
      acc_q <= term;
    end else if (cmd_i.acc_hi) begin
      acc_q <= acc_q + term;
    end
  end

  // output register
  assign out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit && out_free) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && out_free) begin
      oidx_q  <= 3'(cmd_i.idx);
      oval_q  <= emit_val;
      olast_q <= (cmd_i.idx == OUT_LAST);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_index_o = oidx_q;
  assign threshold_o = oval_q;
  assign last_o      = olast_q;

  assign stat_o.blend    = (mode_q == MODE_BLEND);
  assign stat_o.need_div = need_div_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = out_free;

endmodule

// ----- src/tvi_ctrl.sv -----
module tvi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tvi_pkg::tvi_stat_t  stat_i,
  output tvi_pkg::tvi_cmd_t   cmd_o,
  output logic                idle_o
);
  import tvi_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SEARCH = 11'b00000000010,
    ST_ELO    = 11'b00000000100,
    ST_EHI    = 11'b00000001000,
    ST_DIV    = 11'b00000010000,
    ST_RD_LO  = 11'b00000100000,
    ST_MUL_LO = 11'b00001000000,
    ST_ACC_LO = 11'b00010000000,
    ST_MUL_HI = 11'b00100000000,
    ST_ACC_HI = 11'b01000000000,
    ST_EMIT   = 11'b10000000000
  } state_e;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] k_q, k_d;
  logic [COL_W-1:0] idx_q, idx_d;

  function automatic state_e out_entry(input logic blend, input logic [COL_W-1:0] j);
    out_entry = (blend && j != OUT_LAST) ? ST_RD_LO : ST_EMIT;
  endfunction

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.k   = k_q;
    cmd_o.idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SEARCH;
          k_d     = ROW_LAST;
        end
      end
      ST_SEARCH: begin
        cmd_o.srch_en = 1'b1;
        if (k_q == '0) begin
          state_d = ST_ELO;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      ST_ELO: begin
        cmd_o.ld_elo = 1'b1;
        idx_d        = '0;
        state_d      = stat_i.need_div ? ST_EHI : out_entry(stat_i.blend, '0);
      end
      ST_EHI: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = out_entry(stat_i.blend, idx_q);
        end
      end
      ST_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_ACC_LO;
      end
      ST_ACC_LO: begin
        cmd_o.acc_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_ACC_HI;
      end
      ST_ACC_HI: begin
        cmd_o.acc_hi = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.out_free) begin
          if (idx_q == OUT_LAST) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = out_entry(stat_i.blend, idx_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      idx_q   <= idx_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule
